// ----- hdl/led_pattern_generator_assert.svh -----
// assertion macros for the led pattern generator
`ifndef LED_PATTERN_GENERATOR_ASSERT_SVH
`define LED_PATTERN_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define LPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("led pattern generator check failed");
`define LPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("led pattern generator check failed");
`else
`define LPG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LPG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/lpg_pkg.sv -----
// types and constants shared by the led pattern generator
`timescale 1ns / 1ps
package lpg_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned ELAPSE_W = 16;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned DUTY_W   = 8;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// request commands
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAIN_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAIN_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAIN_DUTY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEC_MODE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALT_PERIOD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEC_DUTY    = 3'd5;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ON    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BLINK = 3'd2;
	localparam logic [MODE_W-1:0] MODE_HEART = 3'd3;

	// reset values
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
	localparam logic [DUTY_W-1:0]   DUTY_RST   = 8'd128;

	// heartbeat window edges in percent
	localparam int unsigned HB_PCT_A   = 15;
	localparam int unsigned HB_PCT_B   = 30;
	localparam int unsigned HB_PCT_C   = 45;
	localparam int unsigned HB_PCT_ALL = 100;
	localparam int unsigned HB_W = PERIOD_W + 7;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} lpg_state_t;

	typedef struct packed {
		logic start;
	} lpg_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lpg_div_sts_t;

endpackage

// ----- hdl/lpg_if.sv -----
// request and result channel interfaces
`timescale 1ns / 1ps
interface lpg_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] elapsed_ms;
	logic [31:0] hold_ms;

	modport source (output valid, output command, output elapsed_ms, output hold_ms,
		input ready);
	modport sink (input valid, input command, input elapsed_ms, input hold_ms,
		output ready);
endinterface

interface lpg_out_if;
	logic valid;
	logic ready;
	logic led_level;

	modport source (output valid, output led_level, input ready);
	modport sink (input valid, input led_level, output ready);
endinterface

// ----- hdl/lpg_mod_unit.sv -----
// iterative remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
module lpg_mod_unit
	import lpg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  lpg_div_ctl_t        ctl,
	input  logic [TIME_W-1:0]   dividend,
	input  logic [PERIOD_W-1:0] divisor,
	output lpg_div_sts_t        sts,
	output logic [PERIOD_W-1:0] rem
);

	localparam int unsigned CNT_W = $clog2(TIME_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TIME_W-1:0]   dvd_q;
	logic [PERIOD_W-1:0] div_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;
	logic [PERIOD_W-1:0] rem_nxt;

	// trial is below twice the divisor, so one subtract keeps it reduced
	assign trial = {rem_q, dvd_q[TIME_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign rem_nxt = (trial >= {1'b0, div_q}) ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TIME_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign rem      = rem_q;

endmodule

// ----- hdl/led_pattern_generator.sv -----
// led pattern generator top level: registers, sequencer and level decision
//
//  channel   dir   handshake          payload
//  in_ch     in    valid / ready      command, elapsed_ms, hold_ms
//  out_ch    out   valid / ready      led_level
//  cfg       in    cfg_we             cfg_idx, cfg_wdata
//
// a start request gives no result
// a tick in off or on mode goes from idle to the done state; blink, or heartbeat
// in the main mode, passes through the divide state for the 32-step remainder
// of the time count by the period in lpg_mod_unit before the result is loaded
// in_ch.ready is low while a tick is in work; a result waiting on out_ch holds
// the next tick only at its last step. reset clears time count and timeout
`timescale 1ns / 1ps
`include "led_pattern_generator_assert.svh"
module led_pattern_generator
	import lpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	lpg_in_if.sink                in_ch,
	lpg_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [MODE_W-1:0]   main_mode_q;
	logic [PERIOD_W-1:0] main_period_q;
	logic [DUTY_W-1:0]   main_duty_q;
	logic [MODE_W-1:0]   sec_mode_q;
	logic [PERIOD_W-1:0] alt_period_q;
	logic [DUTY_W-1:0]   sec_duty_q;

	lpg_state_t        state_q;
	logic [TIME_W-1:0] time_accum_q;
	logic [TIME_W-1:0] alt_remaining_q;
	logic              use_alt_q;
	logic              out_valid_q;
	logic              led_q;

	logic                accept;
	logic                tick_acc;
	logic                alt_active;
	logic                needs_div;
	logic [TIME_W-1:0]   time_nxt;
	logic [TIME_W-1:0]   elapsed_ext;
	lpg_div_ctl_t        div_ctl;
	lpg_div_sts_t        div_sts;
	logic [PERIOD_W-1:0] div_rem;
	logic [PERIOD_W-1:0] period_sel;
	logic [DUTY_W-1:0]   duty_sel;
	logic [PERIOD_W-1:0] phase;
	logic [PERIOD_W+DUTY_W-1:0] blink_prod;
	logic                blink_on;
	logic [HB_W-1:0]     ph_x100;
	logic [HB_W-1:0]     per_a;
	logic [HB_W-1:0]     per_b;
	logic [HB_W-1:0]     per_c;
	logic                heart_on;
	logic                level;
	logic                out_load;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_mode_q   <= MODE_OFF;
			main_period_q <= PERIOD_RST;
			main_duty_q   <= DUTY_RST;
			sec_mode_q    <= MODE_OFF;
			alt_period_q  <= PERIOD_RST;
			sec_duty_q    <= DUTY_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAIN_MODE:   main_mode_q   <= cfg_wdata[MODE_W-1:0];
				REG_MAIN_PERIOD: main_period_q <= cfg_wdata[PERIOD_W-1:0];
				REG_MAIN_DUTY:   main_duty_q   <= cfg_wdata[DUTY_W-1:0];
				REG_SEC_MODE:    sec_mode_q    <= cfg_wdata[MODE_W-1:0];
				REG_ALT_PERIOD:  alt_period_q  <= cfg_wdata[PERIOD_W-1:0];
				REG_SEC_DUTY:    sec_duty_q    <= cfg_wdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign tick_acc    = accept && (in_ch.command == CMD_TICK);
	assign alt_active  = (alt_remaining_q != '0);
	assign elapsed_ext = TIME_W'(in_ch.elapsed_ms);
	assign time_nxt    = time_accum_q + elapsed_ext;

	always_comb begin
		if (alt_active) begin
			needs_div = (sec_mode_q == MODE_BLINK);
		end else begin
			needs_div = (main_mode_q == MODE_BLINK) || (main_mode_q == MODE_HEART);
		end
	end

	assign div_ctl.start = tick_acc && needs_div;

	lpg_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (time_nxt),
		.divisor  (alt_active ? alt_period_q : main_period_q),
		.sts      (div_sts),
		.rem      (div_rem)
	);

	// level decision from the phase held in the remainder unit
	assign period_sel = use_alt_q ? alt_period_q : main_period_q;
	assign duty_sel   = use_alt_q ? sec_duty_q : main_duty_q;
	assign phase      = (period_sel == '0) ? '0 : div_rem;
	assign blink_prod = period_sel * duty_sel;
	assign blink_on   = (phase > blink_prod[PERIOD_W+DUTY_W-1:DUTY_W]);

	// compare phase*100 against period*pct instead of dividing by 100
	assign ph_x100  = HB_W'(phase) * HB_W'(HB_PCT_ALL);
	assign per_a    = HB_W'(period_sel) * HB_W'(HB_PCT_A);
	assign per_b    = HB_W'(period_sel) * HB_W'(HB_PCT_B);
	assign per_c    = HB_W'(period_sel) * HB_W'(HB_PCT_C);
	assign heart_on = ((phase != '0) && (ph_x100 <= per_a)) ||
		((ph_x100 > per_b) && (ph_x100 <= per_c));

	always_comb begin
		if (use_alt_q) begin
			case (sec_mode_q)
				MODE_ON:    level = 1'b1;
				MODE_BLINK: level = blink_on;
				default:    level = 1'b0;
			endcase
		end else begin
			case (main_mode_q)
				MODE_ON:    level = 1'b1;
				MODE_BLINK: level = blink_on;
				MODE_HEART: level = heart_on;
				default:    level = 1'b0;
			endcase
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			time_accum_q    <= '0;
			alt_remaining_q <= '0;
			use_alt_q       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_ch.command == CMD_START) begin
							alt_remaining_q <= in_ch.hold_ms;
						end else begin
							time_accum_q <= time_nxt;
							use_alt_q    <= alt_active;
							if (alt_active) begin
								// count down, saturating at zero
								if (alt_remaining_q <= elapsed_ext) begin
									alt_remaining_q <= '0;
								end else begin
									alt_remaining_q <= alt_remaining_q - elapsed_ext;
								end
							end
							state_q <= needs_div ? ST_DIV : ST_DONE;
						end
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			led_q <= level;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.led_level = led_q;

	`LPG_ASSERT_IMP(a_rise_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_DONE))
	`LPG_ASSERT_IMP(a_done_in_div, clk, arst_n, div_sts.done, state_q == ST_DIV)
	`LPG_ASSERT_IMP(a_busy_in_div, clk, arst_n, div_sts.busy, state_q == ST_DIV)
	`LPG_ASSERT_NXT(a_start_no_result, clk, arst_n,
		accept && (in_ch.command == CMD_START) && !out_valid_q, !out_valid_q)
	`LPG_ASSERT_NXT(a_start_keeps_time, clk, arst_n,
		accept && (in_ch.command == CMD_START), $stable(time_accum_q))

endmodule
